// ===== sv/pai_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_pkg
// Shared widths, command and status codes, and the control/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package pai_pkg;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 8;
  localparam int ST_W    = 3;
  localparam int COUNT_W = 7;

  // Command codes on in_cmd
  localparam logic [CMD_W-1:0] CMD_LOAD_START = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_NEXT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

  // Status codes on out_status
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd3;
  localparam logic [ST_W-1:0] ST_ZERO      = 3'd4;
  localparam logic [ST_W-1:0] ST_NO_LOAD   = 3'd5;

  // Decoded operation of the captured item
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_LOAD_START = 3'd1,
    OP_LOAD_NEXT  = 3'd2,
    OP_INSERT     = 3'd3,
    OP_DELETE     = 3'd4,
    OP_READ       = 3'd5
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the input beat
    logic apply;       // commit a load-start or load-next item
    logic issue_read;  // read the entry at the item position
    logic shift_init;  // set up the shift pointer
    logic shift_step;  // move one entry
    logic finish;      // commit insert or delete
    logic emit;        // load the result registers
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic ok;          // item passes its range checks
    logic shift_more;  // entries remain to move
  } dp_sts_t;

endpackage

// ===== sv/positional_array_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_insert_delete
// Ordered store of signed 32-bit words with load, insert, delete and read
// by position; one result beat for every item.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low; busy then
// stays high until the item is done. Every item gives exactly one result
// beat: out_valid is high for one cycle with out_status, out_read_value and
// out_count, and there is no way to hold it off, so capture it when it
// shows. Load-start, load-next, rejected and unused commands finish in the
// evaluate state; a read adds a wait for the memory read; an accepted
// insert or delete steps the shift once per entry moved (count - position
// for insert, count - position - 1 for delete), then drains and finishes.
// The entry memory has one write and one read port, so the shift moves one
// entry per cycle. The result beat of an item shows in the first cycle with
// busy low and overlaps the next accept.
// Entries hold no reset value and need no clearing after reset; reading a
// slot that was never loaded returns whatever the memory holds.
// ----------------------------------------------------------------------------
module positional_array_insert_delete
  import pai_pkg::*;
#(
  parameter int ENTRIES = 64
)(
  input  logic                      clk,
  input  logic                      rst_n,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic [POS_W-1:0]          in_load_count,
  // result side
  output logic                      out_valid,
  output logic [ST_W-1:0]           out_status,
  output logic signed [DATA_W-1:0]  out_read_value,
  output logic [COUNT_W-1:0]        out_count
);

  ctrl_cmd_t ctl_cmd;
  dp_sts_t   dp_sts;

  // sequencer: accept, evaluate, step the shift, emit the result beat
  pai_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (dp_sts),
    .cmd   (ctl_cmd)
  );

  // entry memory, counters and result registers
  pai_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctl_cmd),
    .sts            (dp_sts),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .in_position    (in_position),
    .in_load_count  (in_load_count),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

endmodule

// ===== sv/pai_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_ctrl
// Item sequencer: accepts a beat, evaluates it, steps the entry shift for
// insert and delete, and triggers the result.
// ----------------------------------------------------------------------------
module pai_ctrl
  import pai_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_RDWAIT = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.op == OP_READ && sts.ok) begin
          cmd.issue_read = 1'b1;
          state_nxt      = S_RDWAIT;
        end else if ((sts.op == OP_INSERT || sts.op == OP_DELETE) && sts.ok) begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.apply = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RDWAIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        // advance one entry per cycle while entries remain to move
        if (sts.shift_more) begin
          cmd.shift_step = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        cmd.emit   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/pai_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_dpath
// Entry memory, live count, load pointer, shift pointer and result
// registers.
// ----------------------------------------------------------------------------
module pai_dpath
  import pai_pkg::*;
#(
  parameter int ENTRIES = 64
)(
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctrl_cmd_t                 cmd,
  output dp_sts_t                   sts,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [DATA_W-1:0]  in_value,
  input  logic [POS_W-1:0]          in_position,
  input  logic [POS_W-1:0]          in_load_count,
  output logic                      out_valid,
  output logic [ST_W-1:0]           out_status,
  output logic signed [DATA_W-1:0]  out_read_value,
  output logic [COUNT_W-1:0]        out_count
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = CW + 1;
  localparam int PW = POS_W + 1;

  // captured item
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  lcnt_q;

  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] lidx_r, lidx_nxt;

  logic [DATA_W-1:0] mem [ENTRIES];
  logic [DATA_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  logic [AW-1:0] idx_r;
  logic [AW-1:0] idx_step;
  logic [AW-1:0] idx_src;
  logic          shift_more;
  logic          pend_r;
  logic [AW-1:0] dst_r;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic [COUNT_W-1:0] out_count_r;

  op_t             op;
  logic            ok;
  logic [ST_W-1:0] status_code;
  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   lcnt_ext;
  logic [PW-1:0]   live_ext;
  logic [PW-1:0]   depth_ext;
  logic [AW-1:0]   pos_addr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q   <= in_cmd;
      value_q <= in_value;
      pos_q   <= in_position;
      lcnt_q  <= in_load_count;
    end
  end

  always_comb begin
    unique case (cmd_q)
      CMD_LOAD_START: op = OP_LOAD_START;
      CMD_LOAD_NEXT:  op = OP_LOAD_NEXT;
      CMD_INSERT:     op = OP_INSERT;
      CMD_DELETE:     op = OP_DELETE;
      CMD_READ:       op = OP_READ;
      default:        op = OP_NONE;
    endcase
  end

  assign pos_ext   = {1'b0, pos_q};
  assign lcnt_ext  = {1'b0, lcnt_q};
  assign live_ext  = PW'(live_r);
  assign depth_ext = PW'(ENTRIES);
  assign pos_addr  = pos_q[AW-1:0];

  // range checks and status code
  always_comb begin
    status_code = ST_OK;
    case (op) inside
      OP_LOAD_START: begin
        if (lcnt_ext > depth_ext) begin
          status_code = ST_TOO_LARGE;
        end else if (lcnt_q == '0) begin
          status_code = ST_ZERO;
        end
      end
      OP_LOAD_NEXT: begin
        if (!(lidx_r < live_r)) begin
          status_code = ST_NO_LOAD;
        end
      end
      OP_INSERT: begin
        if (pos_ext > live_ext) begin
          status_code = ST_BAD_POS;
        end else if (live_ext >= depth_ext) begin
          status_code = ST_FULL;
        end
      end
      OP_DELETE, OP_READ: begin
        if (pos_ext >= live_ext) begin
          status_code = ST_BAD_POS;
        end
      end
      default: begin
        status_code = ST_OK;
      end
    endcase
  end

  assign ok = (status_code == ST_OK);

  // shift pointer: insert walks down from the count, delete walks up
  always_comb begin
    if (op == OP_INSERT) begin
      idx_src    = idx_r - AW'(1);
      idx_step   = idx_r - AW'(1);
      shift_more = (idx_r > pos_addr);
    end else begin
      idx_src    = idx_r + AW'(1);
      idx_step   = idx_r + AW'(1);
      shift_more = ((IW'(idx_r) + IW'(1)) < IW'(live_r));
    end
  end

  assign sts.op         = op;
  assign sts.ok         = ok;
  assign sts.shift_more = shift_more;

  always_ff @(posedge clk) begin
    if (cmd.shift_init) begin
      idx_r <= (op == OP_INSERT) ? live_r[AW-1:0] : pos_addr;
    end else if (cmd.shift_step) begin
      idx_r <= idx_step;
    end
    dst_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.shift_step;
    end
  end

  // single write port: shift write, insert value, or load word
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_addr;
    mem_wd = value_q;
    if (pend_r) begin
      mem_we = 1'b1;
      mem_wa = dst_r;
      mem_wd = rdata_r;
    end else if (cmd.finish && op == OP_INSERT) begin
      mem_we = 1'b1;
      mem_wa = pos_addr;
      mem_wd = value_q;
    end else if (cmd.apply && op == OP_LOAD_NEXT && ok) begin
      mem_we = 1'b1;
      mem_wa = lidx_r[AW-1:0];
      mem_wd = value_q;
    end
  end

  assign mem_ra = cmd.shift_step ? idx_src : pos_addr;

  // hold the read word until the shift write or the result takes it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.issue_read || cmd.shift_step) begin
      rdata_r <= mem[mem_ra];
    end
  end

  // live count and load pointer
  always_comb begin
    live_nxt = live_r;
    lidx_nxt = lidx_r;
    if (cmd.apply) begin
      case (op)
        OP_LOAD_START: begin
          live_nxt = ok ? CW'(lcnt_q) : '0;
          lidx_nxt = '0;
        end
        OP_LOAD_NEXT: begin
          if (ok) begin
            lidx_nxt = lidx_r + CW'(1);
          end
        end
        default: begin
          live_nxt = live_r;
        end
      endcase
    end
    if (cmd.finish) begin
      if (op == OP_INSERT) begin
        live_nxt = live_r + CW'(1);
        lidx_nxt = live_r + CW'(1);
      end else begin
        live_nxt = live_r - CW'(1);
        lidx_nxt = live_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      lidx_r <= '0;
    end else begin
      live_r <= live_nxt;
      lidx_r <= lidx_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r     <= status_code;
      out_read_value_r <= (op == OP_READ && ok) ? rdata_r : '0;
      out_count_r      <= COUNT_W'(live_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

endmodule
